>>> hdl/checksummed_frame_receiver_macros.svh
// Assertion macros used by the frame receiver datapath.
`ifndef CHECKSUMMED_FRAME_RECEIVER_MACROS_SVH
`define CHECKSUMMED_FRAME_RECEIVER_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define CFR_ASSERT_SAME(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("frame receiver check failed");

// Condition must hold in the cycle after the trigger.
`define CFR_ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("frame receiver check failed");

`endif

>>> hdl/cfr_pkg.sv
// Shared types and constants for the checksummed frame receiver.
`timescale 1ns / 1ps

package cfr_pkg;

   localparam int MAX_FRAME_LEN_DEFAULT = 31;
   localparam int MIN_FRAME_LEN         = 4;

   localparam logic [7:0] START_BYTE  = 8'h01;
   localparam logic [7:0] END_BYTE    = 8'h02;
   localparam logic [7:0] ACK_CODE    = 8'd32;
   localparam logic [7:0] RESEND_CODE = 8'd31;

   typedef enum logic [1:0] {
      KIND_DATA   = 2'd0,
      KIND_ACK    = 2'd1,
      KIND_RESEND = 2'd2,
      KIND_ERROR  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      CAUSE_NONE     = 2'd0,
      CAUSE_FRAMING  = 2'd1,
      CAUSE_CHECKSUM = 2'd2
   } cause_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_PROC,
      ST_EMIT_RD,
      ST_EMIT_WR
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;     // write request byte into store, latch it for scanning
      logic read;       // fetch the byte at the scan pointer from the store
      logic proc;       // scan one byte and update frame state
      logic emit_addr;  // read port follows the emission pointer
      logic emit_load;  // load one payload byte into the result register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free;   // result register can take a new result this cycle
      logic rescan;     // current byte drops the start byte and rescans
      logic emit;       // current byte completes a good data frame
      logic next_more;  // unscanned bytes remain after the current one
      logic more;       // unscanned bytes remain
      logic emit_last;  // emission pointer is at the final payload byte
   } status_type;

endpackage

>>> hdl/cfr_ram.sv
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps

module cfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/cfr_ctrl.sv
// Sequencing state machine of the frame receiver.
`timescale 1ns / 1ps

module cfr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  cfr_pkg::status_type status,
   output cfr_pkg::cmd_type    cmd
);

   cfr_pkg::state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cfr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         cfr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = cfr_pkg::ST_PROC;
            end
         end
         cfr_pkg::ST_READ: begin
            cmd.read = 1'b1;
            state_in = cfr_pkg::ST_PROC;
         end
         cfr_pkg::ST_PROC: begin
            // hold until the result register has room
            if (status.out_free) begin
               cmd.proc = 1'b1;
               if (status.rescan) begin
                  state_in = cfr_pkg::ST_READ;
               end else if (status.emit) begin
                  state_in = cfr_pkg::ST_EMIT_RD;
               end else if (status.next_more) begin
                  state_in = cfr_pkg::ST_READ;
               end else begin
                  state_in = cfr_pkg::ST_IDLE;
               end
            end
         end
         cfr_pkg::ST_EMIT_RD: begin
            cmd.emit_addr = 1'b1;
            state_in      = cfr_pkg::ST_EMIT_WR;
         end
         cfr_pkg::ST_EMIT_WR: begin
            cmd.emit_addr = 1'b1;
            if (status.out_free) begin
               cmd.emit_load = 1'b1;
               if (!status.emit_last) begin
                  state_in = cfr_pkg::ST_EMIT_RD;
               end else if (status.more) begin
                  state_in = cfr_pkg::ST_READ;
               end else begin
                  state_in = cfr_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = cfr_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> hdl/cfr_datapath.sv
// Byte store, scan pointers, checksum logic and result register.
`timescale 1ns / 1ps

`include "checksummed_frame_receiver_macros.svh"

module cfr_datapath #(
   parameter int MAX_FRAME_LEN = cfr_pkg::MAX_FRAME_LEN_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          req_rx_byte,
   input  cfr_pkg::cmd_type    cmd,
   output cfr_pkg::status_type status,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_kind,
   output logic [7:0]          rsp_data_byte,
   output logic [1:0]          rsp_error_cause,
   output logic                rsp_last
);

   // Circular store, large enough that a frame never wraps onto itself
   localparam int AW    = $clog2(MAX_FRAME_LEN + 2);
   localparam int DEPTH = 2 ** AW;

   logic [AW-1:0] head_ff, head_in;     // next free entry
   logic [AW-1:0] sp_ff, sp_in;         // byte being scanned
   logic [AW-1:0] base_ff, base_in;     // start byte of current frame
   logic [AW-1:0] ep_ff, ep_in;         // emission pointer
   logic [AW-1:0] ep_end_ff, ep_end_in; // final payload byte
   logic          in_frame_ff, in_frame_in;
   logic [7:0]    len_ff, len_in;
   logic [7:0]    sum_ff, sum_in;
   logic [7:0]    first_ff, first_in;   // first payload byte
   logic [7:0]    chk_ff, chk_in;       // checksum byte
   logic [7:0]    cur_ff, cur_in;       // freshly accepted byte
   logic          from_mem_ff, from_mem_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_kind_ff, rsp_kind_in;
   logic [7:0]    rsp_data_ff, rsp_data_in;
   logic [1:0]    rsp_cause_ff, rsp_cause_in;
   logic          rsp_last_ff, rsp_last_in;

   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;
   logic [7:0]    scan_byte;
   logic [AW-1:0] idx;
   logic [7:0]    idx_w;
   logic          out_free;

   // decode of the byte under scan
   logic d_start, d_len, d_bad_len, d_mid, d_judge;
   logic d_end_bad, d_sum_bad, d_ack, d_resend, d_data;
   logic d_result, out_load;

   cfr_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.accept),
      .wr_addr (head_ff),
      .wr_data (req_rx_byte),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_addr   = cmd.emit_addr ? ep_ff : sp_ff;
   assign scan_byte = from_mem_ff ? rd_data : cur_ff;
   assign idx       = sp_ff - base_ff;
   assign idx_w     = 8'(idx);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Classify the byte under scan
   always_comb begin
      d_start   = !in_frame_ff && (scan_byte == cfr_pkg::START_BYTE);
      d_len     = in_frame_ff && (idx_w == 8'd1);
      d_bad_len = d_len && ((scan_byte < 8'(cfr_pkg::MIN_FRAME_LEN))
                            || (scan_byte > 8'(MAX_FRAME_LEN)));
      d_mid     = in_frame_ff && !d_len && (idx_w != len_ff);
      d_judge   = in_frame_ff && !d_len && (idx_w == len_ff);
      d_end_bad = d_judge && (scan_byte != cfr_pkg::END_BYTE);
      d_sum_bad = d_judge && !d_end_bad && (sum_ff != chk_ff);
      d_ack     = d_judge && !d_end_bad && !d_sum_bad
                  && (first_ff == cfr_pkg::ACK_CODE);
      d_resend  = d_judge && !d_end_bad && !d_sum_bad && !d_ack
                  && (first_ff == cfr_pkg::RESEND_CODE);
      d_data    = d_judge && !d_end_bad && !d_sum_bad && !d_ack && !d_resend;
      d_result  = d_bad_len || d_end_bad || d_sum_bad || d_ack || d_resend;
   end

   assign status.out_free  = out_free;
   assign status.rescan    = d_bad_len || d_end_bad;
   assign status.emit      = d_data;
   assign status.next_more = (sp_ff + AW'(1)) != head_ff;
   assign status.more      = sp_ff != head_ff;
   assign status.emit_last = ep_ff == ep_end_ff;

   assign out_load = (cmd.proc && d_result) || cmd.emit_load;

   // Next values of scan state and result register
   always_comb begin
      head_in      = head_ff;
      sp_in        = sp_ff;
      base_in      = base_ff;
      ep_in        = ep_ff;
      ep_end_in    = ep_end_ff;
      in_frame_in  = in_frame_ff;
      len_in       = len_ff;
      sum_in       = sum_ff;
      first_in     = first_ff;
      chk_in       = chk_ff;
      cur_in       = cur_ff;
      from_mem_in  = from_mem_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_cause_in = rsp_cause_ff;
      rsp_last_in  = rsp_last_ff;

      if (cmd.accept) begin
         head_in     = head_ff + AW'(1);
         cur_in      = req_rx_byte;
         from_mem_in = 1'b0;
      end
      if (cmd.read) begin
         from_mem_in = 1'b1;
      end

      if (cmd.proc) begin
         sp_in = sp_ff + AW'(1);
         if (!in_frame_ff) begin
            // hunting: keep a start byte, drop anything else
            if (d_start) begin
               in_frame_in = 1'b1;
               base_in     = sp_ff;
               len_in      = '0;
               sum_in      = '0;
            end else begin
               base_in = sp_ff + AW'(1);
            end
         end else if (d_len) begin
            len_in = scan_byte;
            sum_in = scan_byte;
         end else if (d_mid) begin
            if (idx_w <= len_ff - 8'd2) begin
               sum_in = sum_ff + scan_byte;
            end
            if (idx_w == 8'd2) begin
               first_in = scan_byte;
            end
            if (idx_w == len_ff - 8'd1) begin
               chk_in = scan_byte;
            end
         end else begin
            // frame judged: back to hunting after this byte
            in_frame_in = 1'b0;
            base_in     = sp_ff + AW'(1);
            len_in      = '0;
            sum_in      = '0;
            ep_in       = base_ff + AW'(2);
            ep_end_in   = base_ff + AW'(len_ff) - AW'(2);
         end
         // misplaced end or bad length: drop start byte, rescan the rest
         if (d_bad_len || d_end_bad) begin
            in_frame_in = 1'b0;
            base_in     = base_ff + AW'(1);
            sp_in       = base_ff + AW'(1);
            len_in      = '0;
            sum_in      = '0;
         end
      end

      // single result of a judged frame or an error
      if (cmd.proc && d_result) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         rsp_last_in  = 1'b1;
         if (d_ack) begin
            rsp_kind_in  = cfr_pkg::KIND_ACK;
            rsp_cause_in = cfr_pkg::CAUSE_NONE;
         end else if (d_resend) begin
            rsp_kind_in  = cfr_pkg::KIND_RESEND;
            rsp_cause_in = cfr_pkg::CAUSE_NONE;
         end else if (d_sum_bad) begin
            rsp_kind_in  = cfr_pkg::KIND_ERROR;
            rsp_cause_in = cfr_pkg::CAUSE_CHECKSUM;
         end else begin
            rsp_kind_in  = cfr_pkg::KIND_ERROR;
            rsp_cause_in = cfr_pkg::CAUSE_FRAMING;
         end
      end

      // payload bytes straight from the store
      if (cmd.emit_load) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = cfr_pkg::KIND_DATA;
         rsp_data_in  = rd_data;
         rsp_cause_in = cfr_pkg::CAUSE_NONE;
         rsp_last_in  = ep_ff == ep_end_ff;
         ep_in        = ep_ff + AW'(1);
      end
   end

   // Registers; payload-only registers carry no reset
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         sp_ff        <= '0;
         base_ff      <= '0;
         in_frame_ff  <= 1'b0;
         len_ff       <= '0;
         sum_ff       <= '0;
         from_mem_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         sp_ff        <= sp_in;
         base_ff      <= base_in;
         in_frame_ff  <= in_frame_in;
         len_ff       <= len_in;
         sum_ff       <= sum_in;
         from_mem_ff  <= from_mem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ep_ff        <= ep_in;
      ep_end_ff    <= ep_end_in;
      first_ff     <= first_in;
      chk_ff       <= chk_in;
      cur_ff       <= cur_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_cause_ff <= rsp_cause_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_data_byte   = rsp_data_ff;
   assign rsp_error_cause = rsp_cause_ff;
   assign rsp_last        = rsp_last_ff;

   // A result never overwrites one still waiting to be taken
   `CFR_ASSERT_SAME(a_no_overwrite, clock, reset, out_load, out_free)
   // Stored bytes from the frame start never exceed the longest frame plus one byte
   `CFR_ASSERT_SAME(a_occupancy, clock, reset, 1'b1,
                    (head_ff - base_ff) <= AW'(MAX_FRAME_LEN + 1))
   // Scan pointer stays between frame start and write head
   `CFR_ASSERT_SAME(a_scan_window, clock, reset, 1'b1,
                    (sp_ff - base_ff) <= (head_ff - base_ff))
   // A rescan always restarts hunting one byte past the old start
   `CFR_ASSERT_NEXT(a_rescan, clock, reset, cmd.proc && status.rescan,
                    !in_frame_ff && (sp_ff == base_ff))

endmodule

>>> hdl/checksummed_frame_receiver.sv
// An accepted byte is scanned in PROC, which registers its error, ack or resend result;
// payload bytes follow through EMIT_RD and EMIT_WR; a held result stalls the scan.
// A new byte is accepted only after the last one is scanned; each rescanned byte goes
// through READ and PROC via the store read port, each payload byte EMIT_RD and EMIT_WR.
// req_ready is high only while no byte is being scanned or emitted.
// Reset (synchronous): clears write and scan pointers, frame state and result valid; store kept as is.
`timescale 1ns / 1ps

module checksummed_frame_receiver #(
   parameter int MAX_FRAME_LEN = cfr_pkg::MAX_FRAME_LEN_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_data_byte,
   output logic [1:0] rsp_error_cause,
   output logic       rsp_last
);

   cfr_pkg::cmd_type    cmd;
   cfr_pkg::status_type status;

   // Sequencer
   cfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Store, scan logic and result register
   cfr_datapath #(
      .MAX_FRAME_LEN (MAX_FRAME_LEN)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_rx_byte     (req_rx_byte),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_error_cause (rsp_error_cause),
      .rsp_last        (rsp_last)
   );

endmodule

>>> bench/tb_checksummed_frame_receiver.sv
// Self-checking testbench for the checksummed frame receiver.
`timescale 1ns / 1ps

module tb_checksummed_frame_receiver;

   localparam int STORE_DEPTH = cfr_pkg::MAX_FRAME_LEN_DEFAULT + 1;
   localparam int ITEM_TARGET = 350;   // request bytes in the whole run
   localparam int TAIL_ITEMS  = 60;    // closing stretch with no idling
   localparam int HOLD_AT     = 120;   // byte count that starts the long hold-off
   localparam int LONG_HOLD   = 300;   // cycles the result side holds off
   localparam int DRAIN       = 20;    // cycles allowed after the last expected result
   localparam int STALL_LIMIT = 2000;  // cycles with no handshake before giving up

   typedef struct packed {
      cfr_pkg::kind_type  kind;
      logic [7:0]         data;
      cfr_pkg::cause_type cause;
      logic               last;
   } result_type;

   typedef struct {
      logic [7:0] rx;
      bit         given;   // expected result typed into the row
      result_type want;
   } stim_row_type;

   localparam result_type NO_RESULT =
      '{cfr_pkg::KIND_DATA, 8'h00, cfr_pkg::CAUSE_NONE, 1'b0};
   localparam result_type ACK_RESULT =
      '{cfr_pkg::KIND_ACK, 8'h00, cfr_pkg::CAUSE_NONE, 1'b1};
   localparam result_type RESEND_RESULT =
      '{cfr_pkg::KIND_RESEND, 8'h00, cfr_pkg::CAUSE_NONE, 1'b1};
   localparam result_type SUM_ERR_RESULT =
      '{cfr_pkg::KIND_ERROR, 8'h00, cfr_pkg::CAUSE_CHECKSUM, 1'b1};
   localparam result_type FRAMING_ERR_RESULT =
      '{cfr_pkg::KIND_ERROR, 8'h00, cfr_pkg::CAUSE_FRAMING, 1'b1};

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_data_byte;
   logic [1:0] rsp_error_cause;
   logic       rsp_last;

   checksummed_frame_receiver uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_error_cause (rsp_error_cause),
      .rsp_last        (rsp_last)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Run bookkeeping
   int unsigned bytes_sent = 0;
   int unsigned frames_sent = 0;
   int unsigned failures = 0;
   int unsigned seen_data = 0, seen_ack = 0, seen_resend = 0, seen_error = 0;
   bit          tail_phase = 1'b0;
   bit          long_hold_done = 1'b0;

   result_type  awaited_results[$];
   result_type  decoded[$];

   // Receiver state mirror
   logic [7:0]  rx_store [STORE_DEPTH];
   int unsigned rx_fill = 0;
   bit          rx_in_frame = 1'b0;
   int unsigned rx_len = 0;
   logic [7:0]  rx_sum = 8'h00;

   // Directed requests: hunting, ack, resend, checksum fault, data frame, misplaced end
   stim_row_type directed_table [29] = '{
      '{8'h00, 1'b0, NO_RESULT},
      '{8'h01, 1'b0, NO_RESULT}, '{8'h04, 1'b0, NO_RESULT}, '{8'h20, 1'b0, NO_RESULT},
      '{8'h24, 1'b0, NO_RESULT},
      '{8'h02, 1'b1, ACK_RESULT},
      '{8'h01, 1'b0, NO_RESULT}, '{8'h04, 1'b0, NO_RESULT}, '{8'h1F, 1'b0, NO_RESULT},
      '{8'h23, 1'b0, NO_RESULT},
      '{8'h02, 1'b1, RESEND_RESULT},
      '{8'h01, 1'b0, NO_RESULT}, '{8'h04, 1'b0, NO_RESULT}, '{8'h55, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, NO_RESULT},
      '{8'h02, 1'b1, SUM_ERR_RESULT},
      '{8'h01, 1'b0, NO_RESULT}, '{8'h05, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, NO_RESULT}, '{8'h04, 1'b0, NO_RESULT}, '{8'h02, 1'b0, NO_RESULT},
      // misplaced end; the rescan then finds a start followed by a length too large
      '{8'h01, 1'b0, NO_RESULT}, '{8'h04, 1'b0, NO_RESULT}, '{8'h01, 1'b0, NO_RESULT},
      '{8'h20, 1'b0, NO_RESULT}, '{8'h09, 1'b0, NO_RESULT},
      // length too small
      '{8'h01, 1'b0, NO_RESULT},
      '{8'h03, 1'b1, FRAMING_ERR_RESULT}
   };

   function automatic void go_hunting();
      rx_in_frame = 1'b0;
      rx_fill     = 0;
      rx_len      = 0;
      rx_sum      = 8'h00;
   endfunction

   function automatic void note_result(cfr_pkg::kind_type kind, logic [7:0] data,
                                       cfr_pkg::cause_type cause, logic last);
      result_type r;
      r.kind  = kind;
      r.data  = data;
      r.cause = cause;
      r.last  = last;
      decoded.push_back(r);
   endfunction

   // Scans one byte; returns 1 when the start byte is to be dropped and the store rescanned
   function automatic bit scan_byte(logic [7:0] b);
      int unsigned idx;
      int unsigned i;
      if (!rx_in_frame) begin
         if (b == cfr_pkg::START_BYTE) begin
            rx_store[0] = b;
            rx_fill     = 1;
            rx_in_frame = 1'b1;
            rx_len      = 0;
            rx_sum      = 8'h00;
         end
         return 1'b0;
      end
      if (rx_fill >= STORE_DEPTH) begin
         note_result(cfr_pkg::KIND_ERROR, 8'h00, cfr_pkg::CAUSE_FRAMING, 1'b1);
         return 1'b1;
      end
      idx = rx_fill;
      rx_store[idx] = b;
      rx_fill = idx + 1;
      // length byte
      if (idx == 1) begin
         rx_len = 32'(b);
         if (b < cfr_pkg::MIN_FRAME_LEN || b > cfr_pkg::MAX_FRAME_LEN_DEFAULT) begin
            note_result(cfr_pkg::KIND_ERROR, 8'h00, cfr_pkg::CAUSE_FRAMING, 1'b1);
            return 1'b1;
         end
         rx_sum = b;
         return 1'b0;
      end
      // payload and checksum
      if (idx < rx_len) begin
         if (idx <= rx_len - 2)
            rx_sum = rx_sum + b;
         return 1'b0;
      end
      // end position reached: judge the frame
      if (b != cfr_pkg::END_BYTE) begin
         note_result(cfr_pkg::KIND_ERROR, 8'h00, cfr_pkg::CAUSE_FRAMING, 1'b1);
         return 1'b1;
      end
      if (rx_sum != rx_store[rx_len - 1]) begin
         note_result(cfr_pkg::KIND_ERROR, 8'h00, cfr_pkg::CAUSE_CHECKSUM, 1'b1);
      end else if (rx_store[2] == cfr_pkg::ACK_CODE) begin
         note_result(cfr_pkg::KIND_ACK, 8'h00, cfr_pkg::CAUSE_NONE, 1'b1);
      end else if (rx_store[2] == cfr_pkg::RESEND_CODE) begin
         note_result(cfr_pkg::KIND_RESEND, 8'h00, cfr_pkg::CAUSE_NONE, 1'b1);
      end else begin
         for (i = 2; i <= rx_len - 2; i++)
            note_result(cfr_pkg::KIND_DATA, rx_store[i], cfr_pkg::CAUSE_NONE,
                        (i == rx_len - 2));
      end
      go_hunting();
      return 1'b0;
   endfunction

   // Works out every result one received byte causes, rescans included
   function automatic void decode_byte(logic [7:0] b);
      logic [7:0]  unscanned[$];
      logic [7:0]  refill[$];
      logic [7:0]  cur;
      int unsigned k;
      unscanned.push_back(b);
      while (unscanned.size() > 0) begin
         cur = unscanned[0];
         unscanned.delete(0);
         if (scan_byte(cur)) begin
            refill.delete();
            for (k = 1; k < rx_fill && k < STORE_DEPTH; k++)
               refill.push_back(rx_store[k]);
            foreach (unscanned[j])
               refill.push_back(unscanned[j]);
            while (refill.size() > STORE_DEPTH + 1)
               void'(refill.pop_back());
            unscanned = refill;
            go_hunting();
         end
      end
   endfunction

   // Offers one request byte and waits until it is taken
   task automatic send_byte(logic [7:0] b, bit given, result_type want);
      req_rx_byte <= b;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      decoded.delete();
      decode_byte(b);
      if (given)
         awaited_results.push_back(want);
      else
         foreach (decoded[k])
            awaited_results.push_back(decoded[k]);
      bytes_sent++;
   endtask

   task automatic idle_sender();
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clock);
   endtask

   // Mostly well-formed frames with random content, some noise and faults
   task automatic send_random_frame();
      logic [7:0]  frame_bytes[$];
      logic [7:0]  sum;
      logic [7:0]  b;
      int unsigned len, n_noise, pick, fault, i;
      bit          busy;
      busy    = ($urandom_range(0, 2) != 0);
      n_noise = $urandom_range(0, 2);
      repeat (n_noise) frame_bytes.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 9) == 0)
         len = $urandom_range(cfr_pkg::MIN_FRAME_LEN, cfr_pkg::MAX_FRAME_LEN_DEFAULT);
      else
         len = $urandom_range(cfr_pkg::MIN_FRAME_LEN, 9);
      pick = $urandom_range(0, 99);
      frame_bytes.push_back(cfr_pkg::START_BYTE);
      frame_bytes.push_back(8'(len));
      sum = 8'(len);
      for (i = 2; i <= len - 2; i++) begin
         if (i == 2 && pick < 15)
            b = cfr_pkg::ACK_CODE;
         else if (i == 2 && pick < 30)
            b = cfr_pkg::RESEND_CODE;
         else
            b = 8'($urandom_range(0, 255));
         sum += b;
         frame_bytes.push_back(b);
      end
      frame_bytes.push_back(sum);
      frame_bytes.push_back(cfr_pkg::END_BYTE);
      // inject a fault into some frames
      fault = $urandom_range(0, 99);
      if (fault < 10)
         frame_bytes[frame_bytes.size() - 2] ^= 8'($urandom_range(1, 255));
      else if (fault < 18)
         frame_bytes[frame_bytes.size() - 1] ^= 8'($urandom_range(1, 255));
      else if (fault < 25)
         frame_bytes[n_noise + 1] = $urandom_range(0, 1) ?
               8'($urandom_range(0, cfr_pkg::MIN_FRAME_LEN - 1)) :
               8'($urandom_range(cfr_pkg::MAX_FRAME_LEN_DEFAULT + 1, 255));
      foreach (frame_bytes[k]) begin
         if (busy && !tail_phase && $urandom_range(0, 4) == 0)
            idle_sender();
         send_byte(frame_bytes[k], 1'b0, NO_RESULT);
      end
      frames_sent++;
   endtask

   // Result checker
   always @(posedge clock) begin : result_check
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         case (rsp_kind)
            cfr_pkg::KIND_DATA:   seen_data++;
            cfr_pkg::KIND_ACK:    seen_ack++;
            cfr_pkg::KIND_RESEND: seen_resend++;
            default:              seen_error++;
         endcase
         if (awaited_results.size() == 0) begin
            $error("unexpected result: kind %0d data %0h cause %0d last %0d",
                   rsp_kind, rsp_data_byte, rsp_error_cause, rsp_last);
            failures++;
         end else begin
            want = awaited_results[0];
            awaited_results.delete(0);
            if (rsp_kind !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_kind);
               failures++;
            end
            if (rsp_data_byte !== want.data) begin
               $error("data_byte: expected %0h, got %0h", want.data, rsp_data_byte);
               failures++;
            end
            if (rsp_error_cause !== want.cause) begin
               $error("error_cause: expected %0d, got %0d", want.cause, rsp_error_cause);
               failures++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_last);
               failures++;
            end
         end
      end
   end

   // Result side: random stall bursts, one long hold-off, none in the tail
   initial begin : result_side
      bit stalls_on;
      stalls_on = 1'b1;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (!long_hold_done && bytes_sent >= HOLD_AT) begin
            long_hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (!tail_phase && stalls_on && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
         if ($urandom_range(0, 39) == 0)
            stalls_on = !stalls_on;
      end
   end

   // Watchdog on handshake activity
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   // Request side and verdict
   initial begin : request_side
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_table[r])
         send_byte(directed_table[r].rx, directed_table[r].given, directed_table[r].want);

      while (bytes_sent < ITEM_TARGET) begin
         if (bytes_sent >= ITEM_TARGET - TAIL_ITEMS)
            tail_phase = 1'b1;
         send_random_frame();
      end
      req_valid <= 1'b0;

      // drain
      while (awaited_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (awaited_results.size() != 0) begin
         $error("%0d expected results never arrived", awaited_results.size());
         failures++;
      end

      $display("Run: %0d bytes in %0d random frames plus directed cases, long hold-off %0s",
               bytes_sent, frames_sent, long_hold_done ? "done" : "missed");
      $display("Results: %0d payload, %0d ack, %0d resend, %0d error",
               seen_data, seen_ack, seen_resend, seen_error);
      if (failures == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+hdl
hdl/cfr_pkg.sv
hdl/cfr_ram.sv
hdl/cfr_ctrl.sv
hdl/cfr_datapath.sv
hdl/checksummed_frame_receiver.sv
bench/tb_checksummed_frame_receiver.sv
